// ===== src/ctsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsf_pkg: shared types and constants of the timebase sync filter
// Field widths, configuration defaults, register indexes, controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ctsf_pkg;

  // Fixed field and register widths
  localparam int DATA_W    = 64;
  localparam int INTV_W    = 30;
  localparam int MULT_W    = 32;
  localparam int SHIFT_W   = 6;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Default sizing
  localparam int SAMPLE_DEPTH   = 16;
  localparam int TIMEBASE_COUNT = 2;

  // Configuration reset values
  localparam logic [INTV_W-1:0]  INTV_RST  = 30'd10000000;
  localparam logic [MULT_W-1:0]  MULT_RST  = 32'd161319385;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 6'd21;

  // Serial unit counter widths
  localparam int DIV_CNT_W = $clog2(DATA_W);
  localparam int MUL_CNT_W = $clog2(DATA_W) + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPDATE_INTERVAL = 2'd0,
    REG_NS_MULTIPLIER   = 2'd1,
    REG_NS_SHIFT        = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LIM_DIV,
    S_LIM_WAIT,
    S_LIM_MWAIT,
    S_CONV,
    S_BLK_WAIT,
    S_HI_WAIT,
    S_LO_MUL,
    S_LO_WAIT,
    S_UPD_CHK,
    S_SUM_RD0,
    S_SUM_S0,
    S_SUM_CHK,
    S_SUM_ACC,
    S_AVG_DIV,
    S_AVG_WAIT,
    S_OUT
  } ctsf_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_LIM_DIV,
    OP_LIM_MUL,
    OP_SET_A,
    OP_DIV_BLK,
    OP_CONV_SMALL,
    OP_MUL_HI,
    OP_HI_DONE,
    OP_MUL_LO,
    OP_CONV_DONE,
    OP_UPD_WRITE,
    OP_RD_S0,
    OP_SET_S0,
    OP_RD_IDX,
    OP_ACC,
    OP_AVG_DIV,
    OP_AVG_DONE,
    OP_OUT
  } ctsf_op_e;

  typedef struct packed {
    ctsf_op_e op;
    logic     conv_sel;  // 0: counter snapshot, 1: hardware timestamp
  } ctsf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic mult_zero;
    logic big;
    logic upd_ok;
    logic sum_end;
    logic out_free;
  } ctsf_stat_t;

endpackage

// ===== src/ctsf_ram.sv =====
// ----------------------------------------------------------------------------
// ctsf_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ctsf_ram #(
  parameter int WIDTH = ctsf_pkg::DATA_W,
  parameter int DEPTH = ctsf_pkg::SAMPLE_DEPTH * ctsf_pkg::TIMEBASE_COUNT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ctsf_div.sv =====
// ----------------------------------------------------------------------------
// ctsf_div: iterative 64-bit unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctsf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ctsf_pkg::DATA_W-1:0] dividend_i,
  input  logic [ctsf_pkg::DATA_W-1:0] divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [ctsf_pkg::DATA_W-1:0] quot_o,
  output logic [ctsf_pkg::DATA_W-1:0] rem_o
);

  localparam int DW = ctsf_pkg::DATA_W;
  localparam int CW = ctsf_pkg::DIV_CNT_W;

  logic [DW-1:0] quot_q, quot_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  // Trial subtract of the shifted partial remainder
  assign rem_sh = {rem_q, quot_q[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = !diff[DW];

  // Load operands or advance one quotient bit
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quot_d = {quot_q[DW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/ctsf_dp.sv =====
// ----------------------------------------------------------------------------
// ctsf_dp: datapath of the timebase sync filter
// Configuration, request capture, shift-add multiplier, shared divider,
// per-timebase filter state, sample RAM and the output register.
// ----------------------------------------------------------------------------
module ctsf_dp #(
  parameter int SAMPLE_DEPTH   = ctsf_pkg::SAMPLE_DEPTH,
  parameter int TIMEBASE_COUNT = ctsf_pkg::TIMEBASE_COUNT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ctsf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_func_i,
  input  logic [ctsf_pkg::DATA_W-1:0]    in_sys_i,
  input  logic [ctsf_pkg::DATA_W-1:0]    in_snap_i,
  input  logic [ctsf_pkg::DATA_W-1:0]    in_hw_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ctsf_pkg::DATA_W-1:0]    out_data_o,
  input  ctsf_pkg::ctsf_cmd_t            cmd_i,
  output ctsf_pkg::ctsf_stat_t           stat_o
);

  localparam int DW       = ctsf_pkg::DATA_W;
  localparam int MCW      = ctsf_pkg::MUL_CNT_W;
  localparam int TB_W     = (TIMEBASE_COUNT > 1) ? $clog2(TIMEBASE_COUNT) : 1;
  localparam int IDX_W    = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W    = $clog2(SAMPLE_DEPTH + 1);
  localparam int RAM_AW   = TB_W + IDX_W;
  localparam int RAM_DEPTH = 1 << RAM_AW;

  localparam logic [TB_W-1:0]  TB_LAST  = TB_W'(TIMEBASE_COUNT - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLE_DEPTH);

  // Configuration
  logic [ctsf_pkg::INTV_W-1:0]  intv_q, intv_d;
  logic [ctsf_pkg::MULT_W-1:0]  mult_q, mult_d;
  logic [ctsf_pkg::SHIFT_W-1:0] shift_q, shift_d;

  // Request and conversion registers
  logic [TB_W-1:0] sel_q, sel_d;
  logic [DW-1:0]   now_q, now_d;
  logic [DW-1:0]   snap_q, snap_d;
  logic [DW-1:0]   hw_q, hw_d;
  logic [DW-1:0]   limit_q, limit_d;
  logic [DW-1:0]   a_q, a_d;
  logic [DW-1:0]   conv_hi_q, conv_hi_d;
  logic [DW-1:0]   c_lo_q, c_lo_d;
  logic [DW-1:0]   snap_ns_q, snap_ns_d;
  logic [DW-1:0]   hw_ns_q, hw_ns_d;

  // Averaging registers
  logic [DW-1:0]    acc_q, acc_d;
  logic [DW-1:0]    s0_q, s0_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  // Shift-add multiplier
  logic [DW-1:0]  mul_a_q, mul_a_d;
  logic [DW-1:0]  mul_b_q, mul_b_d;
  logic [DW-1:0]  mul_acc_q, mul_acc_d;
  logic [MCW-1:0] mul_cnt_q, mul_cnt_d;
  logic           mul_busy_q, mul_busy_d;
  logic           mul_done_q, mul_done_d;

  // Per-timebase filter state
  logic [DW-1:0]    last_q [TIMEBASE_COUNT];
  logic [DW-1:0]    last_d [TIMEBASE_COUNT];
  logic [CNT_W-1:0] cnt_q  [TIMEBASE_COUNT];
  logic [CNT_W-1:0] cnt_d  [TIMEBASE_COUNT];
  logic [IDX_W-1:0] wpos_q [TIMEBASE_COUNT];
  logic [IDX_W-1:0] wpos_d [TIMEBASE_COUNT];
  logic [DW-1:0]    filt_q [TIMEBASE_COUNT];
  logic [DW-1:0]    filt_d [TIMEBASE_COUNT];

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] out_data_q, out_data_d;

  // Shared units
  logic              div_start;
  logic [DW-1:0]     div_a;
  logic [DW-1:0]     div_b;
  logic              div_busy;
  logic              div_done;
  logic [DW-1:0]     div_quot;
  logic [DW-1:0]     div_rem;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [DW-1:0]     ram_wdata;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [DW-1:0]     ram_rdata;

  // Shared combinational values
  logic [DW-1:0] cur_c;
  logic [DW-1:0] shifted;
  logic [DW-1:0] upd_lim;
  logic          acc_neg;
  logic [DW-1:0] acc_mag;
  logic          out_free;

  assign cur_c    = cmd_i.conv_sel ? hw_q : snap_q;
  assign shifted  = mul_acc_q >> shift_q;
  assign upd_lim  = last_q[sel_q] + DW'(intv_q);
  assign acc_neg  = acc_q[DW-1];
  assign acc_mag  = acc_neg ? ('0 - acc_q) : acc_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Select divider operands
  always_comb begin
    div_start = 1'b0;
    div_a     = acc_mag;
    div_b     = DW'(cnt_q[sel_q]);
    case (cmd_i.op)
      ctsf_pkg::OP_LIM_DIV: begin
        div_start = 1'b1;
        div_a     = '1;
        div_b     = DW'(mult_q);
      end
      ctsf_pkg::OP_DIV_BLK: begin
        div_start = 1'b1;
        div_a     = cur_c;
        div_b     = limit_q;
      end
      ctsf_pkg::OP_AVG_DIV: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ctsf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Sample ring ports: write the new offset, read slot zero then the others
  assign ram_we    = (cmd_i.op == ctsf_pkg::OP_UPD_WRITE);
  assign ram_waddr = {sel_q, wpos_q[sel_q]};
  assign ram_wdata = now_q - snap_ns_q;
  assign ram_re    = (cmd_i.op == ctsf_pkg::OP_RD_S0) || (cmd_i.op == ctsf_pkg::OP_RD_IDX);
  assign ram_raddr = {sel_q, (cmd_i.op == ctsf_pkg::OP_RD_S0) ? '0 : idx_q[IDX_W-1:0]};

  ctsf_ram #(
    .WIDTH (DW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state of every datapath register
  always_comb begin
    intv_d      = intv_q;
    mult_d      = mult_q;
    shift_d     = shift_q;
    sel_d       = sel_q;
    now_d       = now_q;
    snap_d      = snap_q;
    hw_d        = hw_q;
    limit_d     = limit_q;
    a_d         = a_q;
    conv_hi_d   = conv_hi_q;
    c_lo_d      = c_lo_q;
    snap_ns_d   = snap_ns_q;
    hw_ns_d     = hw_ns_q;
    acc_d       = acc_q;
    s0_d        = s0_q;
    idx_d       = idx_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    mul_acc_d   = mul_acc_q;
    mul_cnt_d   = mul_cnt_q;
    mul_busy_d  = mul_busy_q;
    mul_done_d  = 1'b0;
    last_d      = last_q;
    cnt_d       = cnt_q;
    wpos_d      = wpos_q;
    filt_d      = filt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // Take configuration writes; drop unknown indexes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ctsf_pkg::REG_UPDATE_INTERVAL: begin
          intv_d = cfg_wdata_i[ctsf_pkg::INTV_W-1:0];
        end
        ctsf_pkg::REG_NS_MULTIPLIER: begin
          mult_d = cfg_wdata_i[ctsf_pkg::MULT_W-1:0];
        end
        ctsf_pkg::REG_NS_SHIFT: begin
          shift_d = cfg_wdata_i[ctsf_pkg::SHIFT_W-1:0];
        end
        default: begin
          intv_d = intv_q;
        end
      endcase
    end

    // Release the output register once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Advance the multiplier by one multiplier bit
    if (mul_busy_q) begin
      if (mul_b_q[0]) begin
        mul_acc_d = mul_acc_q + mul_a_q;
      end
      mul_a_d   = {mul_a_q[DW-2:0], 1'b0};
      mul_b_d   = {1'b0, mul_b_q[DW-1:1]};
      mul_cnt_d = mul_cnt_q - 1'b1;
      if (mul_cnt_q == MCW'(1)) begin
        mul_busy_d = 1'b0;
        mul_done_d = 1'b1;
      end
    end

    case (cmd_i.op)
      ctsf_pkg::OP_LOAD: begin
        sel_d     = (32'(in_func_i) >= TIMEBASE_COUNT) ? TB_LAST : TB_W'(in_func_i);
        now_d     = in_sys_i;
        snap_d    = in_snap_i;
        hw_d      = in_hw_i;
        snap_ns_d = '0;
        hw_ns_d   = '0;
      end
      ctsf_pkg::OP_LIM_MUL: begin
        limit_d    = div_quot;
        mul_a_d    = div_quot;
        mul_b_d    = DW'(mult_q);
        mul_acc_d  = '0;
        mul_cnt_d  = MCW'(ctsf_pkg::MULT_W);
        mul_busy_d = 1'b1;
      end
      ctsf_pkg::OP_SET_A: begin
        a_d = shifted;
      end
      ctsf_pkg::OP_CONV_SMALL: begin
        conv_hi_d = '0;
        c_lo_d    = cur_c;
      end
      ctsf_pkg::OP_MUL_HI: begin
        c_lo_d     = div_rem;
        mul_a_d    = a_q;
        mul_b_d    = div_quot;
        mul_acc_d  = '0;
        mul_cnt_d  = MCW'(DW);
        mul_busy_d = 1'b1;
      end
      ctsf_pkg::OP_HI_DONE: begin
        conv_hi_d = mul_acc_q;
      end
      ctsf_pkg::OP_MUL_LO: begin
        mul_a_d    = c_lo_q;
        mul_b_d    = DW'(mult_q);
        mul_acc_d  = '0;
        mul_cnt_d  = MCW'(ctsf_pkg::MULT_W);
        mul_busy_d = 1'b1;
      end
      ctsf_pkg::OP_CONV_DONE: begin
        if (cmd_i.conv_sel) begin
          hw_ns_d = conv_hi_q + shifted;
        end else begin
          snap_ns_d = conv_hi_q + shifted;
        end
      end
      ctsf_pkg::OP_UPD_WRITE: begin
        last_d[sel_q] = now_q;
        wpos_d[sel_q] = (wpos_q[sel_q] == IDX_LAST) ? '0 : wpos_q[sel_q] + 1'b1;
        if (cnt_q[sel_q] < CNT_FULL) begin
          cnt_d[sel_q] = cnt_q[sel_q] + 1'b1;
        end
        acc_d = '0;
        idx_d = CNT_W'(1);
      end
      ctsf_pkg::OP_SET_S0: begin
        s0_d = ram_rdata;
      end
      ctsf_pkg::OP_ACC: begin
        acc_d = acc_q + (ram_rdata - s0_q);
        idx_d = idx_q + 1'b1;
      end
      ctsf_pkg::OP_AVG_DONE: begin
        filt_d[sel_q] = (acc_neg ? ('0 - div_quot) : div_quot) + s0_q;
      end
      ctsf_pkg::OP_OUT: begin
        out_data_d  = hw_ns_q + filt_q[sel_q];
        out_valid_d = 1'b1;
      end
      default: begin
        out_data_d = out_data_q;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intv_q      <= ctsf_pkg::INTV_RST;
      mult_q      <= ctsf_pkg::MULT_RST;
      shift_q     <= ctsf_pkg::SHIFT_RST;
      mul_cnt_q   <= '0;
      mul_busy_q  <= 1'b0;
      mul_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TIMEBASE_COUNT; i++) begin
        last_q[i] <= '0;
        cnt_q[i]  <= '0;
        wpos_q[i] <= '0;
        filt_q[i] <= '0;
      end
    end else begin
      intv_q      <= intv_d;
      mult_q      <= mult_d;
      shift_q     <= shift_d;
      mul_cnt_q   <= mul_cnt_d;
      mul_busy_q  <= mul_busy_d;
      mul_done_q  <= mul_done_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      wpos_q      <= wpos_d;
      filt_q      <= filt_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    sel_q      <= sel_d;
    now_q      <= now_d;
    snap_q     <= snap_d;
    hw_q       <= hw_d;
    limit_q    <= limit_d;
    a_q        <= a_d;
    conv_hi_q  <= conv_hi_d;
    c_lo_q     <= c_lo_d;
    snap_ns_q  <= snap_ns_d;
    hw_ns_q    <= hw_ns_d;
    acc_q      <= acc_d;
    s0_q       <= s0_d;
    idx_q      <= idx_d;
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    mul_acc_q  <= mul_acc_d;
    out_data_q <= out_data_d;
  end

  // Status towards the controller
  assign stat_o.div_done  = div_done;
  assign stat_o.mul_done  = mul_done_q;
  assign stat_o.mult_zero = (mult_q == '0);
  assign stat_o.big       = (cur_c > limit_q);
  assign stat_o.upd_ok    = (now_q >= upd_lim);
  assign stat_o.sum_end   = (idx_q == cnt_q[sel_q]);
  assign stat_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_busy && mul_busy_q))
    else $error("divider and multiplier busy together");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ctsf_pkg::OP_OUT) |-> out_free)
    else $error("output register loaded while a result still waits");

  a_ring_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ctsf_pkg::OP_UPD_WRITE) |->
      ((cnt_q[sel_q] == CNT_FULL) || (CNT_W'(wpos_q[sel_q]) == cnt_q[sel_q])))
    else $error("ring write position out of step with sample count");

  a_count_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ctsf_pkg::OP_UPD_WRITE) |=> (cnt_q[sel_q] != '0))
    else $error("sample count empty after a ring write");
`endif

endmodule

// ===== src/ctsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctsf_ctrl: controller of the timebase sync filter
// Sequences limit computation, both counter conversions, the filter update,
// the ring sum, the averaging divide and the output load.
// ----------------------------------------------------------------------------
module ctsf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ctsf_pkg::ctsf_stat_t stat_i,
  output ctsf_pkg::ctsf_cmd_t  cmd_o
);

  ctsf_pkg::ctsf_state_e state_q, state_d;
  logic                  conv_q, conv_d;

  // Next state
  always_comb begin
    state_d = state_q;
    conv_d  = conv_q;
    case (state_q)
      ctsf_pkg::S_IDLE: begin
        conv_d = 1'b0;
        if (in_valid_i) begin
          state_d = stat_i.mult_zero ? ctsf_pkg::S_UPD_CHK : ctsf_pkg::S_LIM_DIV;
        end
      end
      ctsf_pkg::S_LIM_DIV: begin
        state_d = ctsf_pkg::S_LIM_WAIT;
      end
      ctsf_pkg::S_LIM_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ctsf_pkg::S_LIM_MWAIT;
        end
      end
      ctsf_pkg::S_LIM_MWAIT: begin
        if (stat_i.mul_done) begin
          state_d = ctsf_pkg::S_CONV;
        end
      end
      ctsf_pkg::S_CONV: begin
        state_d = stat_i.big ? ctsf_pkg::S_BLK_WAIT : ctsf_pkg::S_LO_MUL;
      end
      ctsf_pkg::S_BLK_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ctsf_pkg::S_HI_WAIT;
        end
      end
      ctsf_pkg::S_HI_WAIT: begin
        if (stat_i.mul_done) begin
          state_d = ctsf_pkg::S_LO_MUL;
        end
      end
      ctsf_pkg::S_LO_MUL: begin
        state_d = ctsf_pkg::S_LO_WAIT;
      end
      ctsf_pkg::S_LO_WAIT: begin
        if (stat_i.mul_done) begin
          if (conv_q) begin
            state_d = ctsf_pkg::S_UPD_CHK;
          end else begin
            conv_d  = 1'b1;
            state_d = ctsf_pkg::S_CONV;
          end
        end
      end
      ctsf_pkg::S_UPD_CHK: begin
        state_d = stat_i.upd_ok ? ctsf_pkg::S_SUM_RD0 : ctsf_pkg::S_OUT;
      end
      ctsf_pkg::S_SUM_RD0: begin
        state_d = ctsf_pkg::S_SUM_S0;
      end
      ctsf_pkg::S_SUM_S0: begin
        state_d = ctsf_pkg::S_SUM_CHK;
      end
      ctsf_pkg::S_SUM_CHK: begin
        state_d = stat_i.sum_end ? ctsf_pkg::S_AVG_DIV : ctsf_pkg::S_SUM_ACC;
      end
      ctsf_pkg::S_SUM_ACC: begin
        state_d = ctsf_pkg::S_SUM_CHK;
      end
      ctsf_pkg::S_AVG_DIV: begin
        state_d = ctsf_pkg::S_AVG_WAIT;
      end
      ctsf_pkg::S_AVG_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ctsf_pkg::S_OUT;
        end
      end
      ctsf_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          state_d = ctsf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ctsf_pkg::S_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.op       = ctsf_pkg::OP_NONE;
    cmd_o.conv_sel = conv_q;
    case (state_q)
      ctsf_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ctsf_pkg::OP_LOAD;
        end
      end
      ctsf_pkg::S_LIM_DIV: begin
        cmd_o.op = ctsf_pkg::OP_LIM_DIV;
      end
      ctsf_pkg::S_LIM_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = ctsf_pkg::OP_LIM_MUL;
        end
      end
      ctsf_pkg::S_LIM_MWAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.op = ctsf_pkg::OP_SET_A;
        end
      end
      ctsf_pkg::S_CONV: begin
        cmd_o.op = stat_i.big ? ctsf_pkg::OP_DIV_BLK : ctsf_pkg::OP_CONV_SMALL;
      end
      ctsf_pkg::S_BLK_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = ctsf_pkg::OP_MUL_HI;
        end
      end
      ctsf_pkg::S_HI_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.op = ctsf_pkg::OP_HI_DONE;
        end
      end
      ctsf_pkg::S_LO_MUL: begin
        cmd_o.op = ctsf_pkg::OP_MUL_LO;
      end
      ctsf_pkg::S_LO_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.op = ctsf_pkg::OP_CONV_DONE;
        end
      end
      ctsf_pkg::S_UPD_CHK: begin
        if (stat_i.upd_ok) begin
          cmd_o.op = ctsf_pkg::OP_UPD_WRITE;
        end
      end
      ctsf_pkg::S_SUM_RD0: begin
        cmd_o.op = ctsf_pkg::OP_RD_S0;
      end
      ctsf_pkg::S_SUM_S0: begin
        cmd_o.op = ctsf_pkg::OP_SET_S0;
      end
      ctsf_pkg::S_SUM_CHK: begin
        if (!stat_i.sum_end) begin
          cmd_o.op = ctsf_pkg::OP_RD_IDX;
        end
      end
      ctsf_pkg::S_SUM_ACC: begin
        cmd_o.op = ctsf_pkg::OP_ACC;
      end
      ctsf_pkg::S_AVG_DIV: begin
        cmd_o.op = ctsf_pkg::OP_AVG_DIV;
      end
      ctsf_pkg::S_AVG_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = ctsf_pkg::OP_AVG_DONE;
        end
      end
      ctsf_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = ctsf_pkg::OP_OUT;
        end
      end
      default: begin
        cmd_o.op = ctsf_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctsf_pkg::S_IDLE;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      conv_q  <= conv_d;
    end
  end

`ifndef SYNTHESIS
  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == ctsf_pkg::S_LIM_WAIT ||
                         state_q == ctsf_pkg::S_BLK_WAIT ||
                         state_q == ctsf_pkg::S_AVG_WAIT))
    else $error("divider finished outside a divide wait");

  a_mul_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.mul_done |-> (state_q == ctsf_pkg::S_LIM_MWAIT ||
                         state_q == ctsf_pkg::S_HI_WAIT ||
                         state_q == ctsf_pkg::S_LO_WAIT))
    else $error("multiplier finished outside a multiply wait");
`endif

endmodule

// ===== src/counter_timebase_sync_filter_core.sv =====
// ----------------------------------------------------------------------------
// counter_timebase_sync_filter_core: counter timestamp to timebase translator
// Converts raw counter timestamps to ns and adds a moving-average offset
// kept per timebase.
// ----------------------------------------------------------------------------
// Each request carries a timebase select, the current system time, a counter
// snapshot taken with it and a hardware timestamp; exactly one translated
// time comes back per request. Requests are handled one at a time. A request
// is worked through by the bit-serial divider and the shift-add multiplier:
// the overflow limit is derived from the multiplier, then each counter is
// converted, with a further divide and multiply when that counter is above
// the limit, then, when the filter updates, the filled ring entries are
// summed and an averaging divide follows. With a zero multiplier both
// conversions are skipped. A new request is accepted while the previous
// result still waits in the output register. Configuration writes take
// effect at once and are meant for idle periods.
module counter_timebase_sync_filter_core #(
  parameter int SAMPLE_DEPTH   = ctsf_pkg::SAMPLE_DEPTH,
  parameter int TIMEBASE_COUNT = ctsf_pkg::TIMEBASE_COUNT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ctsf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // system_time_ns [63:0], counter_snapshot [127:64], hw_timestamp [191:128]
  input  logic [191:0]                   s_axis_tdata,
  // func [0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // translated_time_ns [63:0]
  output logic [63:0]                    m_axis_tdata
);

  ctsf_pkg::ctsf_cmd_t  cmd;
  ctsf_pkg::ctsf_stat_t stat;

  ctsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ctsf_dp #(
    .SAMPLE_DEPTH   (SAMPLE_DEPTH),
    .TIMEBASE_COUNT (TIMEBASE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (s_axis_tuser),
    .in_sys_i    (s_axis_tdata[63:0]),
    .in_snap_i   (s_axis_tdata[127:64]),
    .in_hw_i     (s_axis_tdata[191:128]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
